/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: whenever ante holds, cons must hold in the same cycle.
`define GLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Never check: expr must not hold at any clock edge.
`define GLC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* rtl/core/glc_pkg.sv */
// ----------------------------------------------------------------------------
// glc_pkg
// Types and constants shared by the G-code line cleaner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glc_pkg;

  localparam logic [7:0] CharUpperN = 8'h4E;
  localparam logic [7:0] CharLowerN = 8'h6E;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharSpace  = 8'h20;

  // Depth of the command queue between front and back, and of the result queue.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned OutDepth = 4;

  // What the back end does with the command's own character.
  typedef enum logic [1:0] {
    CK_NONE,  // nothing (dropped or leading whitespace)
    CK_HOLD,  // whitespace held until a kept non-space follows
    CK_EMIT   // non-space: flush held whitespace, then emit
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    cmd_kind_e  kind;
    logic       n_emit;  // emit a plain 'N' (with flush) before ch
    logic       last;    // final byte of the line
  } cmd_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       line_done;
  } res_t;

endpackage

/* rtl/core/glc_fifo.sv */
// ----------------------------------------------------------------------------
// glc_fifo
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/glc_front.sv */
// ----------------------------------------------------------------------------
// glc_front
// Accepts raw bytes, tracks line-number and checksum scanning, and issues
// one command per byte that has an effect on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glc_front #(
  parameter int unsigned LineBuffer = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    char_in_i,
  input  logic          line_end_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output glc_pkg::cmd_t cmd_o
);

  localparam int unsigned WcW = $clog2(LineBuffer);

  localparam logic [1:0] SM_NORMAL = 2'd0;
  localparam logic [1:0] SM_NPEND  = 2'd1;
  localparam logic [1:0] SM_NUMBER = 2'd2;
  localparam logic [1:0] SM_CHKSUM = 2'd3;

  logic [1:0]     mode_q, mode_d;
  logic [WcW-1:0] wc_q, wc_d;
  logic           ts_q, ts_d;
  logic           accept;
  glc_pkg::cmd_t  cmd;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == glc_pkg::CharSpace) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c == glc_pkg::CharMinus);
  endfunction

  assign accept = push_i && !cmd_full_i;

  always_comb begin
    logic           do_normal;
    logic [WcW-1:0] wc_eff;
    logic [7:0]     cu;

    mode_d    = mode_q;
    wc_d      = wc_q;
    ts_d      = ts_q;
    do_normal = 1'b0;
    cu        = char_in_i;
    cmd.ch     = char_in_i;
    cmd.kind   = glc_pkg::CK_NONE;
    cmd.n_emit = 1'b0;
    cmd.last   = line_end_i;

    unique case (mode_q)
      SM_NPEND: begin
        if (is_num(char_in_i)) begin
          mode_d = SM_NUMBER;
        end else begin
          mode_d     = SM_NORMAL;
          cmd.n_emit = 1'b1;
          ts_d       = 1'b1;
          do_normal  = 1'b1;
        end
      end
      SM_NUMBER: begin
        if (is_num(char_in_i)) begin
          mode_d = SM_NUMBER;
        end else if (char_in_i == glc_pkg::CharSpace) begin
          mode_d = SM_NORMAL;
        end else begin
          mode_d    = SM_NORMAL;
          do_normal = 1'b1;
        end
      end
      SM_CHKSUM: begin
        if (!(char_in_i >= 8'h30 && char_in_i <= 8'h39)) begin
          mode_d    = SM_NORMAL;
          do_normal = 1'b1;
        end
      end
      default: begin
        do_normal = 1'b1;
      end
    endcase

    // The pending 'N' counts as one accepted byte.
    wc_eff = wc_q + WcW'(cmd.n_emit);
    wc_d   = wc_eff;

    if (do_normal && (wc_eff < WcW'(LineBuffer - 1))) begin
      priority if (char_in_i == glc_pkg::CharStar) begin
        mode_d = SM_CHKSUM;
      end else if ((char_in_i == glc_pkg::CharUpperN || char_in_i == glc_pkg::CharLowerN)
                   && !line_end_i) begin
        mode_d = SM_NPEND;
      end else begin
        if (char_in_i >= 8'h61 && char_in_i <= 8'h7A) begin
          cu = char_in_i - 8'd32;
        end
        cmd.ch = cu;
        wc_d   = wc_eff + WcW'(1);
        if (is_ws(cu)) begin
          cmd.kind = ts_d ? glc_pkg::CK_HOLD : glc_pkg::CK_NONE;
        end else begin
          cmd.kind = glc_pkg::CK_EMIT;
          ts_d     = 1'b1;
        end
      end
    end

    if (line_end_i) begin
      mode_d = SM_NORMAL;
      wc_d   = '0;
      ts_d   = 1'b0;
    end
  end

  // Drop bytes that neither emit, hold nor end the line.
  assign cmd_push_o = accept && (cmd.last || cmd.n_emit || (cmd.kind != glc_pkg::CK_NONE));
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= SM_NORMAL;
      wc_q   <= '0;
      ts_q   <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      wc_q   <= wc_d;
      ts_q   <= ts_d;
    end
  end

endmodule

/* rtl/core/glc_back.sv */
// ----------------------------------------------------------------------------
// glc_back
// Executes commands: holds whitespace in a local store, flushes it ahead of
// kept characters, emits characters and end markers into the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module glc_back #(
  parameter int unsigned LineBuffer = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  glc_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    char_out_o,
  output logic          char_valid_o,
  output logic          line_done_o
);

  localparam int unsigned CntW    = $clog2(LineBuffer);
  localparam int unsigned IdxW    = $clog2(LineBuffer - 1);
  localparam int unsigned OutCntW = $clog2(glc_pkg::OutDepth + 1);

  logic [7:0]         store_q [LineBuffer - 1];
  logic [7:0]         rdata_q;
  logic [CntW-1:0]    pend_q, flush_idx_q, pend_base;
  logic               n_done_q;
  logic               stg_valid_q, stg_mem_q;
  glc_pkg::res_t      stg_res_q, stg_res_d, out_res, out_head;
  logic [OutCntW-1:0] out_count;
  logic [OutCntW:0]   occ;
  logic               room, emits;
  logic               want_flush, want_n, want_c, want_mark, want_any;
  logic               sel_flush, sel_n, sel_c, sel_mark, issue, final_step;
  logic               out_full;

  assign occ  = {1'b0, out_count} + (OutCntW + 1)'(stg_valid_q);
  assign room = occ < (OutCntW + 1)'(glc_pkg::OutDepth);

  assign emits      = cmd_i.n_emit || (cmd_i.kind == glc_pkg::CK_EMIT);
  assign want_flush = emits && !n_done_q && (flush_idx_q < pend_q);
  assign want_n     = cmd_i.n_emit && !n_done_q;
  assign want_c     = (cmd_i.kind == glc_pkg::CK_EMIT);
  assign want_mark  = cmd_i.last && !emits;
  assign want_any   = want_flush || want_n || want_c || want_mark;

  // Held whitespace first, then the 'N', then the character itself.
  assign sel_flush = want_flush;
  assign sel_n     = !want_flush && want_n;
  assign sel_c     = !want_flush && !want_n && want_c;
  assign sel_mark  = !want_flush && !want_n && !want_c && want_mark;

  assign issue      = cmd_valid_i && room && want_any;
  assign final_step = sel_c || (sel_n && !want_c) || sel_mark;
  assign cmd_pop_o  = cmd_valid_i && (!want_any || (room && final_step));
  assign pend_base  = emits ? '0 : pend_q;

  always_comb begin
    stg_res_d = '0;
    if (sel_n) begin
      stg_res_d.char_out   = glc_pkg::CharUpperN;
      stg_res_d.char_valid = 1'b1;
      stg_res_d.line_done  = cmd_i.last && !want_c;
    end else if (sel_c) begin
      stg_res_d.char_out   = cmd_i.ch;
      stg_res_d.char_valid = 1'b1;
      stg_res_d.line_done  = cmd_i.last;
    end else if (sel_mark) begin
      stg_res_d.line_done  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      flush_idx_q <= '0;
      n_done_q    <= 1'b0;
      stg_valid_q <= 1'b0;
      stg_mem_q   <= 1'b0;
    end else begin
      stg_valid_q <= issue;
      stg_mem_q   <= issue && sel_flush;
      if (cmd_pop_o) begin
        flush_idx_q <= '0;
        n_done_q    <= 1'b0;
        if (cmd_i.last) begin
          pend_q <= '0;
        end else if (cmd_i.kind == glc_pkg::CK_HOLD) begin
          pend_q <= pend_base + CntW'(1);
        end else begin
          pend_q <= pend_base;
        end
      end else if (issue) begin
        if (sel_flush) begin
          flush_idx_q <= flush_idx_q + CntW'(1);
        end
        if (sel_n) begin
          n_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      stg_res_q <= stg_res_d;
    end
    if (cmd_pop_o && !cmd_i.last && (cmd_i.kind == glc_pkg::CK_HOLD)) begin
      store_q[pend_base[IdxW-1:0]] <= cmd_i.ch;
    end
    if (issue && sel_flush) begin
      rdata_q <= store_q[flush_idx_q[IdxW-1:0]];
    end
  end

  always_comb begin
    out_res = stg_res_q;
    if (stg_mem_q) begin
      out_res.char_out   = rdata_q;
      out_res.char_valid = 1'b1;
      out_res.line_done  = 1'b0;
    end
  end

  glc_fifo #(
    .Width ($bits(glc_pkg::res_t)),
    .Depth (glc_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stg_valid_q),
    .data_i  (out_res),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_head),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  assign char_out_o   = out_head.char_out;
  assign char_valid_o = out_head.char_valid;
  assign line_done_o  = out_head.line_done;

  `GLC_ASSERT_NEVER(a_out_no_overflow, stg_valid_q && out_full, "result queue overflow")

endmodule

/* rtl/core/gcode_line_cleaner_unit.sv */
// ----------------------------------------------------------------------------
// gcode_line_cleaner_unit
// Cleans one G-code line per request stream: strips line numbers and
// checksums, upper-cases, trims whitespace.
// ----------------------------------------------------------------------------
// The unit takes one byte of a G-code line per input request (push/full) and
// returns the cleaned line as a stream of result requests (empty/pop). An 'N'
// or 'n' followed by a digit or '-' opens a line number; the number and one
// following space are dropped. A '*' and the digits after it are dropped.
// Letters are upper-cased, leading and trailing whitespace is removed, and
// whitespace inside the line is held until a kept non-space byte follows. At
// most LINE_BUFFER-1 bytes of a line count; later bytes are ignored until the
// byte flagged line_end_i. The last result of a line has line_done_o set; a
// line that keeps nothing yields one bare end marker (char_valid_o low,
// char_out_o zero). Timing: the front stage accepts one byte per cycle while
// its two-entry command queue has room. The back stage issues one result per
// cycle (each held whitespace byte, 'N', character or end marker) while the
// result queue has room; a byte that only holds whitespace is retired with no
// result, and bytes with no effect take no back-end time. This emit rate,
// through the whitespace store read port, sets sustained throughput. Results
// go via a staging register to a four-entry queue. No clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gcode_line_cleaner_unit #(
  parameter int unsigned LINE_BUFFER = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       line_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out_o,
  output logic       char_valid_o,
  output logic       line_done_o
);

  localparam int unsigned CmdCntW = $clog2(glc_pkg::CmdDepth + 1);

  glc_pkg::cmd_t      cmd_in, cmd_head;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic [CmdCntW-1:0] cmd_count;

  // Hold input requests off while the command queue is full.
  assign full = cmd_full;

  glc_front #(
    .LineBuffer (LINE_BUFFER)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .char_in_i  (char_in_i),
    .line_end_i (line_end_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // Decouple classification from execution so each side stalls on its own.
  glc_fifo #(
    .Width ($bits(glc_pkg::cmd_t)),
    .Depth (glc_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  glc_back #(
    .LineBuffer (LINE_BUFFER)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .char_out_o   (char_out_o),
    .char_valid_o (char_valid_o),
    .line_done_o  (line_done_o)
  );

  // A bare end marker always closes a line and carries a zero character.
  `GLC_ASSERT_IMPL(a_marker_closes_line, !empty && !char_valid_o, line_done_o, "marker not last")
  `GLC_ASSERT_IMPL(a_marker_zero_char, !empty && !char_valid_o, char_out_o == 8'h00, "marker char")
  // The front never issues a command into a full queue.
  `GLC_ASSERT_NEVER(a_cmd_no_overflow, cmd_push && cmd_full, "command queue overflow")
  // Commands are only taken from a non-empty queue whose count agrees.
  `GLC_ASSERT_IMPL(a_cmd_pop_valid, cmd_pop, !cmd_empty && cmd_count != '0, "cmd queue empty")

endmodule

/* bench/gcode_line_cleaner_unit_test.sv */
// ----------------------------------------------------------------------------
// gcode_line_cleaner_unit_test
// Self-checking bench for the G-code line cleaner: sends whole lines one byte
// per request and compares every returned character against an in-bench
// line cleaner that tracks line numbers, checksums, held whitespace and the
// per-line byte cap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcode_line_cleaner_unit_test;

  localparam int unsigned LineBuffer  = 64;
  localparam int unsigned LineCap     = LineBuffer - 1;
  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned RandomItems = 50;
  localparam int unsigned LatencyTail = 16;
  localparam int unsigned CycleLimit  = 3000000;

  // Byte classes used by the cleaner's scanner.
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CaseOffset = 8'h20;

  typedef enum logic [1:0] {
    ScanText,
    ScanNPending,
    ScanNumber,
    ScanChecksum
  } scan_mode_e;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       push         = 1'b0;
  logic       full;
  logic [7:0] char_in_i    = glc_pkg::CharSpace;
  logic       line_end_i   = 1'b0;
  logic       empty;
  logic       pop          = 1'b0;
  logic [7:0] char_out_o;
  logic       char_valid_o;
  logic       line_done_o;

  gcode_line_cleaner_unit #(
    .LINE_BUFFER(LineBuffer)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_in_i   (char_in_i),
    .line_end_i  (line_end_i),
    .empty       (empty),
    .pop         (pop),
    .char_out_o  (char_out_o),
    .char_valid_o(char_valid_o),
    .line_done_o (line_done_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Line cleaner state mirrored in the bench
  // --------------------------------------------------------------------------
  scan_mode_e  scan_mode    = ScanText;
  int unsigned bytes_taken  = 0;
  bit          text_started = 1'b0;
  logic [7:0]  held_blanks[$];

  glc_pkg::res_t step_out[$];    // results caused by the current request
  glc_pkg::res_t cleaned_q[$];   // cleaned characters still owed by the block
  logic [7:0]    line_bytes[$];  // line under construction for the sender

  int          error_count  = 0;
  int          items_sent   = 0;
  int          cycle_count  = 0;
  int          rx_hold      = 0;  // long receiver hold-off, counted down per cycle
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;

  function automatic bit is_digit(input logic [7:0] ch);
    return ch >= CharZero && ch <= CharNine;
  endfunction

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == glc_pkg::CharSpace || (ch >= CharTab && ch <= CharCr);
  endfunction

  function automatic bit is_number_char(input logic [7:0] ch);
    return is_digit(ch) || ch == glc_pkg::CharMinus;
  endfunction

  // Take one byte into the line: hold whitespace, or flush held whitespace
  // ahead of a kept non-space byte.
  function automatic void take_char(input logic [7:0] ch);
    bytes_taken++;
    if (is_blank(ch)) begin
      // leading whitespace is dropped outright
      if (text_started && held_blanks.size() < LineBuffer) held_blanks.push_back(ch);
      return;
    end
    foreach (held_blanks[i]) step_out.push_back(glc_pkg::res_t'{held_blanks[i], 1'b1, 1'b0});
    held_blanks.delete();
    text_started = 1'b1;
    step_out.push_back(glc_pkg::res_t'{ch, 1'b1, 1'b0});
  endfunction

  // Plain text scanning; a line that reached its cap ignores the byte.
  function automatic void scan_plain(input logic [7:0] ch, input logic last);
    logic [7:0] up;
    if (bytes_taken >= LineCap) return;
    up = ch;
    if (ch == glc_pkg::CharStar) begin
      scan_mode = ScanChecksum;
    end else if ((ch == glc_pkg::CharUpperN || ch == glc_pkg::CharLowerN) && !last) begin
      scan_mode = ScanNPending;
    end else begin
      if (ch >= CharLowerA && ch <= CharLowerZ) up = ch - CaseOffset;
      take_char(up);
    end
  endfunction

  // Work out the results one accepted request causes and queue them.
  function automatic void predict_cleaned(input logic [7:0] ch, input logic last);
    glc_pkg::res_t tail;
    step_out.delete();
    case (scan_mode)
      ScanNPending: begin
        if (is_number_char(ch)) begin
          scan_mode = ScanNumber;
        end else begin
          // no number after all: the N is an ordinary letter
          scan_mode = ScanText;
          take_char(glc_pkg::CharUpperN);
          scan_plain(ch, last);
        end
      end
      ScanNumber: begin
        if (ch == glc_pkg::CharSpace) begin
          scan_mode = ScanText;  // drop one space after the line number
        end else if (!is_number_char(ch)) begin
          scan_mode = ScanText;
          scan_plain(ch, last);
        end
      end
      ScanChecksum: begin
        if (!is_digit(ch)) begin
          scan_mode = ScanText;
          scan_plain(ch, last);
        end
      end
      default: scan_plain(ch, last);
    endcase
    if (last) begin
      // an end that keeps nothing in this request yields a bare end marker
      if (step_out.size() == 0) step_out.push_back(glc_pkg::res_t'{8'h00, 1'b0, 1'b0});
      tail = step_out.pop_back();
      tail.line_done = 1'b1;
      step_out.push_back(tail);
      scan_mode    = ScanText;
      bytes_taken  = 0;
      text_started = 1'b0;
      held_blanks.delete();
    end
    foreach (step_out[i]) cleaned_q.push_back(step_out[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Idling
  // --------------------------------------------------------------------------
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one byte and hold it until the block takes it.
  task automatic send_char(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    char_in_i  <= ch;
    line_end_i <= last;
    // full is stable mid-cycle; the request goes through at the next edge
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
    predict_cleaned(ch, last);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_char(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  // Drop the request line and wait until every owed character came back.
  task automatic wait_drained();
    push <= 1'b0;
    while (cleaned_q.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Random line builder
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(CharTab, CharCr));
    return glc_pkg::CharSpace;
  endfunction

  function automatic void add_digits(input int max_digits);
    int n;
    n = $urandom_range(1, max_digits);
    repeat (n) line_bytes.push_back(CharZero + 8'($urandom_range(0, 9)));
  endfunction

  // Mostly well-formed lines with random content, some raw noise.
  function automatic void build_line(input int min_len);
    string letters;
    logic [7:0] letter;
    int words;
    letters = "GMXYZFSEN";
    line_bytes.delete();
    if ($urandom_range(0, 5) == 0 && min_len == 0) begin
      // noise: any byte but zero, including broken numbers and stray stars
      repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(1, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
    if ($urandom_range(0, 2) == 0) begin
      line_bytes.push_back($urandom_range(0, 1) ? glc_pkg::CharUpperN : glc_pkg::CharLowerN);
      if ($urandom_range(0, 4) == 0) line_bytes.push_back(glc_pkg::CharMinus);
      add_digits(4);
      if ($urandom_range(0, 3) != 0) line_bytes.push_back(glc_pkg::CharSpace);
    end
    words = $urandom_range(1, 4);
    while (words > 0 || line_bytes.size() < min_len) begin
      letter = letters[$urandom_range(0, letters.len() - 1)];
      if ($urandom_range(0, 2) == 0) letter = letter + CaseOffset;
      line_bytes.push_back(letter);
      if ($urandom_range(0, 3) == 0) line_bytes.push_back(glc_pkg::CharMinus);
      add_digits(3);
      if ($urandom_range(0, 2) == 0) begin
        line_bytes.push_back(CharDot);
        add_digits(3);
      end
      repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
      words--;
    end
    if ($urandom_range(0, 2) == 0) begin
      line_bytes.push_back(glc_pkg::CharStar);
      add_digits(3);
    end
    repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: drive pop, with random stalls and a long hold-off on demand
  // --------------------------------------------------------------------------
  initial begin : drive_pop
    int stall;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop   <= 1'b1;
        stall = pick_gap(rx_steady);
      end
    end
  end

  // Compare each result request, mid-cycle, against the oldest owed character.
  always @(negedge clk_i) begin : check_results
    glc_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (cleaned_q.size() == 0) begin
        $error("unexpected result: char_out %02h char_valid %0b line_done %0b",
               char_out_o, char_valid_o, line_done_o);
        error_count++;
      end else begin
        want = cleaned_q.pop_front();
        if (char_out_o !== want.char_out) begin
          $error("char_out: expected %02h, got %02h", want.char_out, char_out_o);
          error_count++;
        end
        if (char_valid_o !== want.char_valid) begin
          $error("char_valid: expected %0b, got %0b", want.char_valid, char_valid_o);
          error_count++;
        end
        if (line_done_o !== want.line_done) begin
          $error("line_done: expected %0b, got %0b", want.line_done, line_done_o);
          error_count++;
        end
      end
    end
  end

  // Hard stop for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Leading whitespace, a lower-case line number with a minus, the dropped
  // space after it, lower-case letters and a trailing checksum.
  task automatic test_number_and_checksum();
    send_text(" \tn-3 g1*9");
  endtask

  // N without a number becomes a plain letter; an N on the final byte too.
  task automatic test_plain_n();
    send_text("Na bN");
  endtask

  // Byte extremes, trailing whitespace, a whitespace-only line that keeps
  // nothing, and a star on the final byte after a number.
  task automatic test_edges_and_empty();
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(glc_pkg::CharSpace, 1'b1);
    send_char(CharTab, 1'b1);
    send_text("N5X*");
  endtask

  // Hold the receiver off while a line longer than the cap streams in, so
  // the block fills and stalls its input; later bytes hit the cap.
  task automatic test_backpressure_full_line();
    rx_hold   = 200;
    tx_steady = 1'b1;
    build_line(LineBuffer + 16);
    send_line();
    tx_steady = 1'b0;
  endtask

  // Let the sender go quiet until all owed characters have come back.
  task automatic test_sender_pause();
    repeat (3) begin
      build_line(0);
      send_line();
    end
    wait_drained();
    build_line(0);
    send_line();
  endtask

  // Run both sides without idling for a few lines.
  task automatic test_back_to_back();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (4) begin
      build_line(0);
      send_line();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_lines();
    int start;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      // now and then push a line past the cap
      build_line($urandom_range(0, 15) == 0 ? LineBuffer + 4 : 0);
      send_line();
    end
  endtask

  initial begin
    // Hold reset, then release it at a rising edge.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_number_and_checksum();
    test_plain_n();
    test_edges_and_empty();
    test_backpressure_full_line();
    test_sender_pause();
    test_back_to_back();
    test_random_lines();

    // Drain, then give stray results a chance to show up.
    wait_drained();
    repeat (LatencyTail) @(posedge clk_i);

    if (cleaned_q.size() != 0) begin
      $error("%0d cleaned characters never arrived", cleaned_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* gcode_line_cleaner_unit.f */
+incdir+rtl/core
rtl/core/glc_pkg.sv
rtl/core/glc_fifo.sv
rtl/core/glc_front.sv
rtl/core/glc_back.sv
rtl/core/gcode_line_cleaner_unit.sv
bench/gcode_line_cleaner_unit_test.sv
